// ===== sv/per_class_confidence_tracker_defines.svh =====
// assertion macros for the per-class confidence tracker
`ifndef PER_CLASS_CONFIDENCE_TRACKER_DEFINES_SVH
`define PER_CLASS_CONFIDENCE_TRACKER_DEFINES_SVH
`ifndef ASSERT_OFF
`define PCT_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define PCT_ASSERT_NORST(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define PCT_ASSERT(label, clk, rst_n, prop, msg)
`define PCT_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== sv/pct_pkg.sv =====
// types and constants of the per-class confidence tracker
`default_nettype none
package pct_pkg;
    localparam logic [16:0] Q_ONE   = 17'd32768;
    localparam logic [15:0] SD_LOW  = 16'd1638;
    localparam logic [15:0] SD_HIGH = 16'd16384;
    localparam logic [15:0] HALF    = 16'd16384;

    localparam logic [2:0] CFG_INIT_MEAN   = 3'd0;
    localparam logic [2:0] CFG_INIT_STDDEV = 3'd1;
    localparam logic [2:0] CFG_INIT_RATE   = 3'd2;
    localparam logic [2:0] CFG_BASE_LR     = 3'd3;
    localparam logic [2:0] CFG_RATE_SMOOTH = 3'd4;

    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic        op;
        logic [3:0]  task_class;
        logic        outcome;
        logic [15:0] pred_prob;
    } in_word_t;

    typedef struct packed {
        logic [15:0] mean_out;
        logic [15:0] stddev_out;
        logic [15:0] rate_out;
        logic [15:0] calib_error_out;
        logic [15:0] accuracy_out;
    } out_word_t;

    // clamp a value to one in Q1.15
    function automatic logic [15:0] sat_one(input logic [15:0] v);
        sat_one = (v > 16'd32768) ? 16'd32768 : v;
    endfunction
endpackage
`default_nettype wire

// ===== sv/per_class_confidence_tracker.sv =====
// per-class confidence tracker: table of class statistics with update and query
//
// Usage: in_valid/in_ready/in_data carry one word per item (update or query of a
// class); out_valid/out_ready/out_data return one word per item with the class
// mean, uncertainty, rate, calibration error and accuracy after the item.
// cfg_valid/cfg_ready/cfg_index/cfg_data write the five Q1.15 settings; write
// them only while the block is idle.
// One item at a time: an update passes after acceptance through the memory read,
// the registered arithmetic steps LR, MEAN, SD, SDC and RATE, the write-back and
// a one-bit-per-cycle restoring divider of COUNT_BITS + 15 steps for accuracy; a
// query skips the arithmetic and the write-back and goes on to the divider.
// in_ready rises as soon as the result is loaded into the output register, so a
// stalled receiver only holds the single finished word.
// Reset clears the valid bits of all classes and loads the setting defaults;
// the statistics memories are not cleared, untouched classes read as settings.
`default_nettype none
`include "per_class_confidence_tracker_defines.svh"
module per_class_confidence_tracker #(
    parameter int NUM_CLASSES = 16,
    parameter int COUNT_BITS  = 32
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 in_valid,
    output logic                in_ready,
    input  wire pct_pkg::in_word_t in_data,
    output logic                out_valid,
    input  wire                 out_ready,
    output pct_pkg::out_word_t  out_data,
    input  wire                 cfg_valid,
    output logic                cfg_ready,
    input  wire  [2:0]          cfg_index,
    input  wire  [15:0]         cfg_data
);
    localparam int AW = (NUM_CLASSES > 1) ? $clog2(NUM_CLASSES) : 1;
    localparam int EW = 4 * 16 + 2 * COUNT_BITS;
    localparam int DW = COUNT_BITS + 15;
    localparam int CW = $clog2(DW + 1);
    localparam logic [COUNT_BITS-1:0] CMAX = {COUNT_BITS{1'b1}};

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_READ = 4'd1;
    localparam logic [3:0] S_LOAD = 4'd2;
    localparam logic [3:0] S_LR   = 4'd3;
    localparam logic [3:0] S_MEAN = 4'd4;
    localparam logic [3:0] S_SD   = 4'd5;
    localparam logic [3:0] S_SDC  = 4'd6;
    localparam logic [3:0] S_RATE = 4'd7;
    localparam logic [3:0] S_WB   = 4'd8;
    localparam logic [3:0] S_DIV  = 4'd9;
    localparam logic [3:0] S_DONE = 4'd10;

    // constant table folding the class index onto the table depth
    function automatic logic [AW-1:0] wrap_class(input logic [3:0] c);
        logic [AW-1:0] r;
        r = '0;
        for (int i = 0; i < 16; i++)
            if (c == 4'(i))
                r = AW'(i % NUM_CLASSES);
        return r;
    endfunction

    // settings
    logic [15:0] init_mean_reg, init_stddev_reg, init_rate_reg, base_lr_reg, smooth_reg;
    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_mean_reg   <= 16'd16384;
            init_stddev_reg <= 16'd9830;
            init_rate_reg   <= 16'd16384;
            base_lr_reg     <= 16'd4915;
            smooth_reg      <= 16'd4915;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                pct_pkg::CFG_INIT_MEAN:   init_mean_reg   <= cfg_data;
                pct_pkg::CFG_INIT_STDDEV: init_stddev_reg <= cfg_data;
                pct_pkg::CFG_INIT_RATE:   init_rate_reg   <= cfg_data;
                pct_pkg::CFG_BASE_LR:     base_lr_reg     <= cfg_data;
                pct_pkg::CFG_RATE_SMOOTH: smooth_reg      <= cfg_data;
                default: ;
            endcase
        end
    end

    // entry memory and valid bits
    logic [EW-1:0] mem [NUM_CLASSES];
    logic [EW-1:0] rd_data_reg;
    logic [NUM_CLASSES-1:0] valid_reg;
    logic [3:0] state_reg;
    logic [AW-1:0] addr_reg;
    logic op_reg, hit_reg;
    logic [15:0] pp_reg;
    logic [15:0] mean_reg, sd_reg, rate_reg, calib_reg, lr_reg, err_reg;
    logic [COUNT_BITS-1:0] total_reg, hits_reg;
    logic [33:0] prod_reg;
    logic [DW-1:0] rem_reg, quo_reg;
    logic [COUNT_BITS:0] part_reg;
    logic [CW-1:0] cnt_reg;
    logic out_valid_reg;
    pct_pkg::out_word_t out_reg;

    logic [AW-1:0] in_addr;
    assign in_addr = wrap_class(in_data.task_class);
    assign in_ready = (state_reg == S_IDLE);
    wire accept = in_valid && in_ready;

    always_ff @(posedge clk)
    begin
        if (accept)
            rd_data_reg <= mem[in_addr];
        if (state_reg == S_WB && op_reg == pct_pkg::OP_UPDATE)
            mem[addr_reg] <= {mean_reg, sd_reg, rate_reg, calib_reg, total_reg, hits_reg};
    end

    // arithmetic helpers
    wire [16:0] o_val = hit_reg ? pct_pkg::Q_ONE : 17'd0;
    wire [15:0] base_s = pct_pkg::sat_one(base_lr_reg);
    wire [15:0] a_s    = pct_pkg::sat_one(smooth_reg);
    wire [33:0] lr_prod = 34'(base_s) * 34'(17'(pct_pkg::Q_ONE + 17'(sd_reg)));
    wire [16:0] lr_raw = (lr_prod[33:15] > 19'd32768) ? 17'd32768 : lr_prod[31:15];
    wire [33:0] mean_prod = 34'(17'(pct_pkg::Q_ONE - 17'(lr_reg))) * 34'(mean_reg)
                          + (hit_reg ? 34'(lr_reg) << 15 : 34'd0);
    wire [15:0] mean_n = mean_prod[30:15];
    wire [16:0] err_n  = hit_reg ? 17'(pct_pkg::Q_ONE - 17'(mean_n)) : 17'(mean_n);
    wire [20:0] err10  = 21'(err_reg) * 21'd10;
    wire [33:0] sd_mul = (err10 < 21'(pct_pkg::Q_ONE)) ? 34'(sd_reg) * 34'd49
                       : (err10 < 21'd98304) ? 34'(sd_reg) * 34'd99
                       : 34'(sd_reg) * 34'(err_reg);
    wire [33:0] rate_prod = 34'(a_s) * 34'(o_val)
                          + 34'(17'(pct_pkg::Q_ONE - 17'(a_s))) * 34'(rate_reg);
    wire [15:0] rate_n = rate_prod[30:15];
    wire [15:0] pp_s   = pct_pkg::sat_one(pp_reg);
    // constant divides of the sd product: /50 and /100 as a pre-shift then a
    // reciprocal multiply by 1/25, /163840 as a shift by 15 then 1/5
    wire [19:0] q25_in   = (err10 < 21'(pct_pkg::Q_ONE)) ? prod_reg[20:1] : prod_reg[21:2];
    wire [40:0] q25_prod = 41'(q25_in) * 41'd1342178;
    wire [15:0] q25      = q25_prod[40:25];
    wire [15:0] q5_in    = prod_reg[30:15];
    wire [32:0] q5_prod  = 33'(q5_in) * 33'd104858;
    wire [13:0] q5       = q5_prod[32:19];
    wire [33:0] sd_div = (err10 < 21'd98304) ? 34'(q25)
                       : 34'(sd_reg) + 34'(q5);
    wire [DW:0] trial = {part_reg[COUNT_BITS-1:0], rem_reg[DW-1]} - (DW+1)'(total_reg);
    wire [COUNT_BITS:0] shifted = {part_reg[COUNT_BITS-1:0], rem_reg[DW-1]};
    wire ge = shifted >= (COUNT_BITS+1)'(total_reg);
    wire [DW-1:0] quo_fin = quo_reg;
    wire [15:0] acc_n = (total_reg == '0) ? pct_pkg::HALF
                      : (quo_fin > DW'(32768)) ? 16'd32768 : quo_fin[15:0];

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            valid_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && (!out_valid_reg || out_ready))
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
            unique case (state_reg)
                S_IDLE: if (accept) state_reg <= S_READ;
                S_READ: state_reg <= S_LOAD;
                S_LOAD: state_reg <= (op_reg == pct_pkg::OP_UPDATE) ? S_LR : S_WB;
                S_LR:   state_reg <= S_MEAN;
                S_MEAN: state_reg <= S_SD;
                S_SD:   state_reg <= S_SDC;
                S_SDC:  state_reg <= S_RATE;
                S_RATE: state_reg <= S_WB;
                S_WB:
                begin
                    if (op_reg == pct_pkg::OP_UPDATE)
                        valid_reg[addr_reg] <= 1'b1;
                    state_reg <= S_DIV;
                end
                S_DIV:  if (cnt_reg == '0) state_reg <= S_DONE;
                S_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                        state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
                if (accept)
                begin
                    addr_reg <= in_addr;
                    op_reg   <= in_data.op;
                    hit_reg  <= in_data.outcome;
                    pp_reg   <= in_data.pred_prob;
                end
            S_LOAD:
                if (valid_reg[addr_reg])
                    {mean_reg, sd_reg, rate_reg, calib_reg, total_reg, hits_reg} <= rd_data_reg;
                else
                begin
                    mean_reg  <= pct_pkg::sat_one(init_mean_reg);
                    sd_reg    <= pct_pkg::sat_one(init_stddev_reg);
                    rate_reg  <= pct_pkg::sat_one(init_rate_reg);
                    calib_reg <= '0;
                    total_reg <= '0;
                    hits_reg  <= '0;
                end
            S_LR: lr_reg <= lr_raw[15:0];
            S_MEAN:
            begin
                mean_reg <= mean_n;
                err_reg  <= err_n[15:0];
                if (total_reg != CMAX) total_reg <= total_reg + 1'b1;
                if (hit_reg && hits_reg != CMAX) hits_reg <= hits_reg + 1'b1;
            end
            S_SD: prod_reg <= sd_mul;
            S_SDC:
            begin
                if (sd_div < 34'(pct_pkg::SD_LOW)) sd_reg <= pct_pkg::SD_LOW;
                else if (sd_div > 34'(pct_pkg::SD_HIGH)) sd_reg <= pct_pkg::SD_HIGH;
                else sd_reg <= sd_div[15:0];
            end
            S_RATE:
            begin
                rate_reg  <= rate_n;
                calib_reg <= (pp_s > rate_n) ? pp_s - rate_n : rate_n - pp_s;
            end
            S_WB:
            begin
                rem_reg  <= {hits_reg, 15'd0};
                quo_reg  <= '0;
                part_reg <= '0;
                cnt_reg  <= CW'(DW - 1);
            end
            S_DIV:
            begin
                rem_reg  <= rem_reg << 1;
                quo_reg  <= {quo_reg[DW-2:0], ge};
                part_reg <= ge ? trial[COUNT_BITS:0] : shifted;
                cnt_reg  <= cnt_reg - 1'b1;
            end
            S_DONE:
                if (!out_valid_reg || out_ready)
                begin
                    out_reg.mean_out        <= mean_reg;
                    out_reg.stddev_out      <= sd_reg;
                    out_reg.rate_out        <= rate_reg;
                    out_reg.calib_error_out <= calib_reg;
                    out_reg.accuracy_out    <= acc_n;
                end
            default: ;
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    // checks
    `PCT_ASSERT(a_busy_no_ready, clk, rst_n, (state_reg != S_IDLE) |-> !in_ready, "ready while busy")
    `PCT_ASSERT(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result dropped")
    `PCT_ASSERT(a_accept_read, clk, rst_n, accept |=> (state_reg == S_READ), "no read after accept")
    `PCT_ASSERT(a_sd_clamp, clk, rst_n, (state_reg == S_RATE) |-> (sd_reg >= pct_pkg::SD_LOW && sd_reg <= pct_pkg::SD_HIGH), "sd out of band")
endmodule
`default_nettype wire
